// ===== hdl/trn_pkg.sv =====
`timescale 1ns / 1ps

package trn_pkg;

  // Telnet command and option bytes
  localparam logic [7:0] TEL_IAC  = 8'hFF;
  localparam logic [7:0] TEL_DONT = 8'hFE;
  localparam logic [7:0] TEL_DO   = 8'hFD;
  localparam logic [7:0] TEL_WONT = 8'hFC;
  localparam logic [7:0] TEL_WILL = 8'hFB;
  localparam logic [7:0] TEL_IP   = 8'hF4;
  localparam logic [7:0] TEL_SUSP = 8'hED;
  localparam logic [7:0] OPT_ECHO = 8'h01;
  localparam logic [7:0] OPT_SGA  = 8'h03;

  // user stream characters
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_SUB = 8'h1A;

  localparam int unsigned MaxRes = 6;
  localparam int unsigned CntW   = 3;

  localparam logic [3:0] INSIST_LIMIT_RST = 4'd4;
  localparam logic [4:0] INSIST_MAX       = 5'd31;

  // configuration register indexes
  localparam logic REG_CLIENT_ROLE  = 1'b0;
  localparam logic REG_INSIST_LIMIT = 1'b1;

  // mode_request codes
  localparam logic [1:0] REQ_LINE     = 2'd0;
  localparam logic [1:0] REQ_CHAR     = 2'd1;
  localparam logic [1:0] REQ_LINEMODE = 2'd2;

  typedef enum logic [1:0] {
    OP_RX    = 2'd0,
    OP_START = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_LINE = 2'd1,
    MODE_CHAR = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    PH_DATA = 3'b001,
    PH_IAC  = 3'b010,
    PH_CMD  = 3'b100
  } phase_e;

  // all results of one input item
  typedef struct packed {
    logic                 ch;     // 0 user, 1 peer
    logic [CntW-1:0]      cnt;    // number of bytes, 0 when none
    logic [MaxRes-1:0][7:0] bytes;
    logic [1:0]           nego;
    logic [2:0]           flags;
  } rec_t;

endpackage

// ===== hdl/trn_core.sv =====
`timescale 1ns / 1ps

module trn_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                acc_i,
  input  logic [1:0]          operation_i,
  input  logic [7:0]          rx_byte_i,
  input  logic [1:0]          mode_request_i,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [3:0]          cfg_data_i,
  output trn_pkg::rec_t       rec_o
);

  trn_pkg::phase_e phase_q, phase_d;
  trn_pkg::mode_e  cur_q, cur_d, h_cur;
  logic [7:0] held_q, held_d;
  logic       want_char_q, want_char_d;
  logic [4:0] ic_q, ic_d, h_ic, ic_bump;
  logic       cr_q, cr_d;
  logic [2:0] flags_q, flags_d, ub_flags;
  logic       role_q;
  logic [3:0] limit_q;

  logic [7:0] req_do, req_dont, peer_will, peer_wont;
  logic [7:0] ub, h_cmd;
  logic       echo_sga, is_neg_cmd, h_send, handled, fallback, server;

  assign server    = ~role_q;
  assign req_do    = role_q ? trn_pkg::TEL_DO   : trn_pkg::TEL_WILL;
  assign req_dont  = role_q ? trn_pkg::TEL_DONT : trn_pkg::TEL_WONT;
  assign peer_will = role_q ? trn_pkg::TEL_WILL : trn_pkg::TEL_DO;
  assign peer_wont = role_q ? trn_pkg::TEL_WONT : trn_pkg::TEL_DONT;

  assign ic_bump  = (ic_q == trn_pkg::INSIST_MAX) ? ic_q : ic_q + 5'd1;
  assign echo_sga = (rx_byte_i == trn_pkg::OPT_ECHO) || (rx_byte_i == trn_pkg::OPT_SGA);
  assign is_neg_cmd = (rx_byte_i == trn_pkg::TEL_DO) || (rx_byte_i == trn_pkg::TEL_DONT) ||
                      (rx_byte_i == trn_pkg::TEL_WILL) || (rx_byte_i == trn_pkg::TEL_WONT);

  // user byte: NUL right after CR turns into LF
  assign ub = (cr_q && rx_byte_i == trn_pkg::CH_NUL) ? trn_pkg::CH_LF : rx_byte_i;
  assign ub_flags = flags_q | {server && ub == trn_pkg::CH_SUB,
                               server && ub == trn_pkg::CH_EOT,
                               server && ub == trn_pkg::CH_ETX};

  // option reply for held command + received option byte
  always_comb begin
    h_ic    = ic_q;
    h_cur   = cur_q;
    h_send  = 1'b0;
    h_cmd   = trn_pkg::TEL_DONT;
    handled = 1'b0;
    if (echo_sga) begin
      if (want_char_q) begin
        if (held_q == peer_will) begin
          if (rx_byte_i == trn_pkg::OPT_ECHO) h_cur = trn_pkg::MODE_CHAR;
          handled = 1'b1;
        end else if (held_q == peer_wont) begin
          h_ic    = ic_bump;
          h_send  = (ic_bump <= {1'b0, limit_q});
          h_cmd   = req_do;
          handled = 1'b1;
        end
      end else begin
        if (held_q == peer_wont) begin
          handled = 1'b1;
        end else if (held_q == peer_will) begin
          h_ic    = ic_bump;
          h_send  = (ic_bump <= {1'b0, limit_q});
          h_cmd   = req_dont;
          handled = 1'b1;
        end
      end
    end
    if (!handled) begin
      h_send = 1'b1;
      h_cmd  = (held_q == trn_pkg::TEL_DO || held_q == trn_pkg::TEL_DONT) ?
               trn_pkg::TEL_WONT : trn_pkg::TEL_DONT;
    end
  end

  // give up on character mode: fall back to line negotiation
  assign fallback = (h_cur == trn_pkg::MODE_NONE) && want_char_q && (h_ic > {1'b0, limit_q});

  always_comb begin
    phase_d     = phase_q;
    cur_d       = cur_q;
    held_d      = held_q;
    want_char_d = want_char_q;
    ic_d        = ic_q;
    cr_d        = cr_q;
    flags_d     = flags_q;
    rec_o       = '0;
    rec_o.ch    = 1'b1;

    case (trn_pkg::op_e'(operation_i))
      trn_pkg::OP_RX: begin
        case (phase_q)
          trn_pkg::PH_IAC: begin
            phase_d = trn_pkg::PH_DATA;
            if (rx_byte_i == trn_pkg::TEL_IAC) begin
              cr_d           = 1'b0;
              rec_o.ch       = 1'b0;
              rec_o.cnt      = 3'd1;
              rec_o.bytes[0] = trn_pkg::TEL_IAC;
            end else if (is_neg_cmd) begin
              held_d  = rx_byte_i;
              phase_d = trn_pkg::PH_CMD;
            end else if (rx_byte_i == trn_pkg::TEL_IP) begin
              if (server) flags_d = flags_q | 3'b001;
            end else if (rx_byte_i == trn_pkg::TEL_SUSP) begin
              if (server) flags_d = flags_q | 3'b100;
            end
          end
          trn_pkg::PH_CMD: begin
            phase_d = trn_pkg::PH_DATA;
            ic_d    = h_ic;
            cur_d   = h_cur;
            if (h_send) begin
              rec_o.cnt      = 3'd3;
              rec_o.bytes[0] = trn_pkg::TEL_IAC;
              rec_o.bytes[1] = h_cmd;
              rec_o.bytes[2] = rx_byte_i;
            end
            if (fallback) begin
              want_char_d = 1'b0;
              cur_d       = trn_pkg::MODE_LINE;
              ic_d        = '0;
              rec_o.cnt   = 3'd6;
              if (h_send) begin
                // only the first request of the fallback fits
                rec_o.bytes[3] = trn_pkg::TEL_IAC;
                rec_o.bytes[4] = req_dont;
                rec_o.bytes[5] = trn_pkg::OPT_ECHO;
              end else begin
                rec_o.bytes[0] = trn_pkg::TEL_IAC;
                rec_o.bytes[1] = req_dont;
                rec_o.bytes[2] = trn_pkg::OPT_ECHO;
                rec_o.bytes[3] = trn_pkg::TEL_IAC;
                rec_o.bytes[4] = req_dont;
                rec_o.bytes[5] = trn_pkg::OPT_SGA;
              end
            end
          end
          default: begin
            phase_d = trn_pkg::PH_DATA;
            if (rx_byte_i == trn_pkg::TEL_IAC) begin
              phase_d = trn_pkg::PH_IAC;
            end else begin
              cr_d           = (rx_byte_i == trn_pkg::CH_CR);
              flags_d        = ub_flags;
              rec_o.ch       = 1'b0;
              rec_o.cnt      = 3'd1;
              rec_o.bytes[0] = ub;
            end
          end
        endcase
      end
      trn_pkg::OP_START: begin
        ic_d           = '0;
        rec_o.cnt      = 3'd6;
        rec_o.bytes[0] = trn_pkg::TEL_IAC;
        rec_o.bytes[2] = trn_pkg::OPT_ECHO;
        rec_o.bytes[3] = trn_pkg::TEL_IAC;
        rec_o.bytes[5] = trn_pkg::OPT_SGA;
        if (mode_request_i == trn_pkg::REQ_LINE) begin
          want_char_d    = 1'b0;
          cur_d          = trn_pkg::MODE_LINE;
          rec_o.bytes[1] = req_dont;
          rec_o.bytes[4] = req_dont;
        end else begin
          want_char_d    = 1'b1;
          cur_d          = trn_pkg::MODE_NONE;
          rec_o.bytes[1] = req_do;
          rec_o.bytes[4] = req_do;
        end
      end
      trn_pkg::OP_CLEAR: begin
        flags_d = '0;
      end
      default: begin
      end
    endcase

    rec_o.nego  = cur_d;
    rec_o.flags = flags_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= trn_pkg::PH_DATA;
      cur_q       <= trn_pkg::MODE_NONE;
      held_q      <= '0;
      want_char_q <= 1'b1;
      ic_q        <= '0;
      cr_q        <= 1'b0;
      flags_q     <= '0;
    end else if (acc_i) begin
      phase_q     <= phase_d;
      cur_q       <= cur_d;
      held_q      <= held_d;
      want_char_q <= want_char_d;
      ic_q        <= ic_d;
      cr_q        <= cr_d;
      flags_q     <= flags_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      role_q  <= 1'b1;
      limit_q <= trn_pkg::INSIST_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        trn_pkg::REG_CLIENT_ROLE:  role_q  <= cfg_data_i[0];
        trn_pkg::REG_INSIST_LIMIT: limit_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hdl/trn_rec_fifo.sv =====
`timescale 1ns / 1ps

module trn_rec_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  trn_pkg::rec_t wdata_i,
  input  logic          pop_i,
  output trn_pkg::rec_t head_o,
  output logic          empty_o,
  output logic          full_o
);

  trn_pkg::rec_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== hdl/trn_out_seq.sv =====
`timescale 1ns / 1ps

module trn_out_seq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  trn_pkg::rec_t head_i,
  input  logic          empty_i,
  input  logic          out_stall_i,
  output logic          pop_o,
  output logic          out_valid_o,
  output logic          channel_o,
  output logic [7:0]    out_byte_o,
  output logic          last_o,
  output logic [1:0]    nego_state_o,
  output logic          interrupt_seen_o,
  output logic          eof_seen_o,
  output logic          suspend_seen_o
);

  logic [trn_pkg::CntW-1:0] idx_q;
  logic xfer;

  assign out_valid_o      = ~empty_i;
  assign channel_o        = head_i.ch;
  assign out_byte_o       = head_i.bytes[idx_q];
  assign last_o           = (idx_q == head_i.cnt - 3'd1);
  assign nego_state_o     = head_i.nego;
  assign interrupt_seen_o = head_i.flags[0];
  assign eof_seen_o       = head_i.flags[1];
  assign suspend_seen_o   = head_i.flags[2];

  assign xfer  = out_valid_o && !out_stall_i;
  assign pop_o = xfer && last_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (xfer) begin
      idx_q <= last_o ? '0 : idx_q + 3'd1;
    end
  end

endmodule

// ===== hdl/telnet_receive_negotiator_top.sv =====
`timescale 1ns / 1ps
// Channel | Handshake                  | Payload
// input   | in_valid_i / in_stall_o    | operation_i, rx_byte_i, mode_request_i
// output  | out_valid_o / out_stall_i  | channel_o, out_byte_o, last_o, nego_state_o,
//         |                            | interrupt_seen_o, eof_seen_o, suspend_seen_o
// config  | cfg_we_i                   | cfg_idx_i, cfg_data_i
//
// One input item per cycle while in_stall_o is low; parse and negotiation
// state update in the accept cycle. An item's results (0 to 6 bytes) land in a
// two-entry result queue and leave one byte per cycle while out_stall_i is low.
// in_stall_o is high only while both queue entries are occupied.
// Reset: character mode wanted, nothing negotiated, client role, insist limit 4.

module telnet_receive_negotiator_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] rx_byte_i,
  input  logic [1:0] mode_request_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       channel_o,
  output logic [7:0] out_byte_o,
  output logic       last_o,
  output logic [1:0] nego_state_o,
  output logic       interrupt_seen_o,
  output logic       eof_seen_o,
  output logic       suspend_seen_o,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [3:0] cfg_data_i
);

  trn_pkg::rec_t rec, head;
  logic acc, push, pop, empty, full;

  assign in_stall_o = full;
  assign acc        = in_valid_i && !full;
  assign push       = acc && (rec.cnt != '0);

  trn_core u_core (
    .clk_i,
    .rst_ni,
    .acc_i          (acc),
    .operation_i,
    .rx_byte_i,
    .mode_request_i,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .rec_o          (rec)
  );

  trn_rec_fifo u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .wdata_i (rec),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .full_o  (full)
  );

  trn_out_seq u_seq (
    .clk_i,
    .rst_ni,
    .head_i           (head),
    .empty_i          (empty),
    .out_stall_i,
    .pop_o            (pop),
    .out_valid_o,
    .channel_o,
    .out_byte_o,
    .last_o,
    .nego_state_o,
    .interrupt_seen_o,
    .eof_seen_o,
    .suspend_seen_o
  );

endmodule

// ===== hdl/trn_checker.sv =====
`timescale 1ns / 1ps

module trn_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       channel_o,
  input logic [7:0] out_byte_o,
  input logic       last_o,
  input logic [1:0] nego_state_o,
  input logic       interrupt_seen_o,
  input logic       eof_seen_o,
  input logic       suspend_seen_o
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a user byte is always the only result of its item
  a_user_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !channel_o |-> last_o)
    else $error("user byte not marked last");

  // bytes of one item follow each other with the same status and channel
  a_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=>
      out_valid_o && $stable(channel_o) && $stable(nego_state_o) &&
      $stable(interrupt_seen_o) && $stable(eof_seen_o) && $stable(suspend_seen_o))
    else $error("multi-byte result broken up");

  // peer replies always open with IAC
  a_iac_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_o ##1 out_valid_o && channel_o |->
      out_byte_o == trn_pkg::TEL_IAC)
    else $error("reply does not start with IAC");

endmodule

bind telnet_receive_negotiator_top trn_checker u_trn_checker (.*);
